// ===== rtl/nor_flash_command_interface_unit_assert.svh =====
// Assertion macros used by the checker file of the flash command interface.
`ifndef NOR_FLASH_COMMAND_INTERFACE_UNIT_ASSERT_SVH
`define NOR_FLASH_COMMAND_INTERFACE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NFCI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("flash interface check failed");

// Next-cycle implication, disabled while reset is low.
`define NFCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("flash interface check failed");

`endif

// ===== rtl/nfci_pkg.sv =====
// Types, command codes and status constants of the flash command interface.
package nfci_pkg;

    typedef enum logic [2:0] {
        MODE_ARRAY  = 3'd0,
        MODE_STATUS = 3'd1,
        MODE_ID     = 3'd2,
        MODE_PROG   = 3'd3,
        MODE_ERASE  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PROG,
        ST_ERASE
    } t_state;

    localparam logic [7:0] CMD_READ_ARRAY  = 8'hFF;
    localparam logic [7:0] CMD_READ_STATUS = 8'h70;
    localparam logic [7:0] CMD_READ_ID     = 8'h90;
    localparam logic [7:0] CMD_CLEAR_STAT  = 8'h50;
    localparam logic [7:0] CMD_PROGRAM     = 8'h40;
    localparam logic [7:0] CMD_ERASE       = 8'h20;
    localparam logic [7:0] CMD_CONFIRM     = 8'hD0;

    localparam logic [7:0] STAT_READY     = 8'h80;
    localparam logic [7:0] STAT_ERASE_ERR = 8'h20;
    localparam logic [7:0] STAT_PROG_ERR  = 8'h10;
    localparam logic [7:0] STAT_VPP_LOW   = 8'h08;
    localparam logic [7:0] STAT_LOCKED    = 8'h02;

    localparam logic [15:0] MANUF_CODE = 16'h0089;

    localparam logic [1:0] REG_LOCK_MASK   = 2'd0;
    localparam logic [1:0] REG_VPP_OK      = 2'd1;
    localparam logic [1:0] REG_DEVICE_CODE = 2'd2;

    localparam logic [15:0] LOCK_MASK_RST   = 16'h0000;
    localparam logic        VPP_OK_RST      = 1'b1;
    localparam logic [15:0] DEVICE_CODE_RST = 16'd24;

    function automatic logic [31:0] both_halves(input logic [15:0] h);
        both_halves = {h, h};
    endfunction

endpackage

// ===== rtl/nor_flash_command_interface_unit.sv =====
// Word-mode NOR flash array behind a command interface, array held in one RAM.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | i_in_valid / o_in_stall    | i_cmd, i_word_addr, i_wdata
//  out      | o_out_valid / i_out_stall  | o_rdata, o_mode_now
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// Command writes and status or id reads finish in ST_IDLE; array reads and programs
// go through ST_READ or ST_PROG (one RAM read, then result or write-back); a block
// erase writes its 2^min(BLOCK_ADDR_BITS, WORD_ADDR_BITS) words to ones in ST_ERASE.
// After reset a clearing pass writes all 2^WORD_ADDR_BITS words to ones, one per
// cycle, with o_in_stall high; configuration writes are taken during it.
// One result can wait in a holding slot while the output register is stalled.
module nor_flash_command_interface_unit #(
    parameter int WORD_ADDR_BITS  = 12,
    parameter int BLOCK_ADDR_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [WORD_ADDR_BITS-1:0] i_word_addr,
    input  logic [31:0]               i_wdata,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [31:0]               o_rdata,
    output logic [2:0]                o_mode_now,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int EFF_BLK = (BLOCK_ADDR_BITS < WORD_ADDR_BITS) ? BLOCK_ADDR_BITS
                                                                 : WORD_ADDR_BITS;
    localparam logic [WORD_ADDR_BITS-1:0] OFF_MASK =
        WORD_ADDR_BITS'((64'd1 << EFF_BLK) - 64'd1);
    localparam int DEPTH = 1 << WORD_ADDR_BITS;

    logic [31:0] array_mem [DEPTH];

    nfci_pkg::t_state          r_state, n_state;
    nfci_pkg::t_mode           r_mode, n_mode;
    logic [7:0]                r_status, n_status;
    logic [15:0]               r_lock;
    logic                      r_vpp;
    logic [15:0]               r_dev;
    logic [WORD_ADDR_BITS-1:0] r_cnt, n_cnt;
    logic [WORD_ADDR_BITS-1:0] r_addr;
    logic [31:0]               r_data;
    logic [31:0]               r_mem_q;
    logic                      r_out_valid, n_out_valid;
    logic [31:0]               r_out_rdata, n_out_rdata;
    logic [2:0]                r_out_mode, n_out_mode;
    logic                      r_pend_valid, n_pend_valid;
    logic [31:0]               r_pend_rdata, n_pend_rdata;
    logic [2:0]                r_pend_mode, n_pend_mode;

    logic                      in_accept;
    logic                      cfg_wr;
    logic [7:0]                code;
    logic [WORD_ADDR_BITS-1:0] blk;
    logic [WORD_ADDR_BITS-1:0] offs;
    logic                      locked;
    logic                      mem_we;
    logic [WORD_ADDR_BITS-1:0] mem_waddr;
    logic [31:0]               mem_wdata;
    logic                      res_valid;
    logic [31:0]               res_rdata;
    logic                      out_free;

    assign o_in_stall  = (r_state != nfci_pkg::ST_IDLE) || r_pend_valid;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_out_rdata;
    assign o_mode_now  = r_out_mode;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign code   = i_wdata[7:0];
    assign blk    = i_word_addr >> BLOCK_ADDR_BITS;
    assign offs   = i_word_addr & OFF_MASK;
    // blocks sixteen and above have no lock bit
    assign locked = ((blk >> 4) == '0) && r_lock[blk[3:0]];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            nfci_pkg::REG_LOCK_MASK:   prdata = {16'd0, r_lock};
            nfci_pkg::REG_VPP_OK:      prdata = {31'd0, r_vpp};
            nfci_pkg::REG_DEVICE_CODE: prdata = {16'd0, r_dev};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= nfci_pkg::LOCK_MASK_RST;
            r_vpp  <= nfci_pkg::VPP_OK_RST;
            r_dev  <= nfci_pkg::DEVICE_CODE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                nfci_pkg::REG_LOCK_MASK:   r_lock <= pwdata[15:0];
                nfci_pkg::REG_VPP_OK:      r_vpp  <= pwdata[0];
                nfci_pkg::REG_DEVICE_CODE: r_dev  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // array RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            array_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_mem_q <= array_mem[i_word_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_status   = r_status;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_waddr  = r_cnt;
        mem_wdata  = '1;
        res_valid  = 1'b0;
        res_rdata  = 32'd0;

        case (r_state)
            nfci_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + WORD_ADDR_BITS'(1);
                if (r_cnt == '1) begin
                    n_state = nfci_pkg::ST_IDLE;
                end
            end
            nfci_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (!i_cmd) begin
                        case (r_mode)
                            nfci_pkg::MODE_ARRAY: n_state = nfci_pkg::ST_READ;
                            nfci_pkg::MODE_ID: begin
                                res_valid = 1'b1;
                                if (offs == '0) begin
                                    res_rdata = nfci_pkg::both_halves(nfci_pkg::MANUF_CODE);
                                end else if (offs == WORD_ADDR_BITS'(1)) begin
                                    res_rdata = nfci_pkg::both_halves(r_dev);
                                end
                            end
                            default: begin
                                res_valid = 1'b1;
                                res_rdata = nfci_pkg::both_halves({8'd0, r_status});
                            end
                        endcase
                    end else if (r_mode == nfci_pkg::MODE_PROG) begin
                        res_valid = 1'b1;
                        n_mode    = nfci_pkg::MODE_STATUS;
                        if (!r_vpp) begin
                            n_status = r_status | nfci_pkg::STAT_VPP_LOW
                                                | nfci_pkg::STAT_PROG_ERR;
                        end else if (locked) begin
                            n_status = r_status | nfci_pkg::STAT_LOCKED
                                                | nfci_pkg::STAT_PROG_ERR;
                        end else begin
                            n_state = nfci_pkg::ST_PROG;
                        end
                    end else if (r_mode == nfci_pkg::MODE_ERASE) begin
                        res_valid = 1'b1;
                        n_mode    = nfci_pkg::MODE_STATUS;
                        if (code != nfci_pkg::CMD_CONFIRM) begin
                            n_status = r_status | nfci_pkg::STAT_PROG_ERR
                                                | nfci_pkg::STAT_ERASE_ERR;
                        end else if (!r_vpp) begin
                            n_status = r_status | nfci_pkg::STAT_VPP_LOW
                                                | nfci_pkg::STAT_ERASE_ERR;
                        end else if (locked) begin
                            n_status = r_status | nfci_pkg::STAT_LOCKED
                                                | nfci_pkg::STAT_ERASE_ERR;
                        end else begin
                            n_cnt   = '0;
                            n_state = nfci_pkg::ST_ERASE;
                        end
                    end else begin
                        res_valid = 1'b1;
                        case (code)
                            nfci_pkg::CMD_READ_ARRAY:  n_mode = nfci_pkg::MODE_ARRAY;
                            nfci_pkg::CMD_READ_STATUS: n_mode = nfci_pkg::MODE_STATUS;
                            nfci_pkg::CMD_READ_ID:     n_mode = nfci_pkg::MODE_ID;
                            nfci_pkg::CMD_CLEAR_STAT:  n_status = nfci_pkg::STAT_READY;
                            nfci_pkg::CMD_PROGRAM:     n_mode = nfci_pkg::MODE_PROG;
                            nfci_pkg::CMD_ERASE:       n_mode = nfci_pkg::MODE_ERASE;
                            default: ;
                        endcase
                    end
                end
            end
            nfci_pkg::ST_READ: begin
                res_valid = 1'b1;
                res_rdata = r_mem_q;
                n_state   = nfci_pkg::ST_IDLE;
            end
            nfci_pkg::ST_PROG: begin
                // program can only clear bits
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_mem_q & r_data;
                n_state   = nfci_pkg::ST_IDLE;
            end
            nfci_pkg::ST_ERASE: begin
                mem_we    = 1'b1;
                mem_waddr = (r_addr & ~OFF_MASK) | r_cnt;
                n_cnt     = r_cnt + WORD_ADDR_BITS'(1);
                if (r_cnt == OFF_MASK) begin
                    n_state = nfci_pkg::ST_IDLE;
                end
            end
            default: n_state = nfci_pkg::ST_IDLE;
        endcase
    end

    // output register with one holding slot behind it
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_rdata  = r_out_rdata;
        n_out_mode   = r_out_mode;
        n_pend_valid = r_pend_valid;
        n_pend_rdata = r_pend_rdata;
        n_pend_mode  = r_pend_mode;
        if (r_pend_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_out_rdata  = r_pend_rdata;
            n_out_mode   = r_pend_mode;
            n_pend_valid = 1'b0;
        end else if (res_valid) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_rdata = res_rdata;
                n_out_mode  = n_mode;
            end else begin
                n_pend_valid = 1'b1;
                n_pend_rdata = res_rdata;
                n_pend_mode  = n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nfci_pkg::ST_CLEAR;
            r_mode       <= nfci_pkg::MODE_ARRAY;
            r_status     <= nfci_pkg::STAT_READY;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_status     <= n_status;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr <= i_word_addr;
            r_data <= i_wdata;
        end
        r_out_rdata  <= n_out_rdata;
        r_out_mode   <= n_out_mode;
        r_pend_rdata <= n_pend_rdata;
        r_pend_mode  <= n_pend_mode;
    end

endmodule

// ===== rtl/nfci_checker.sv =====
// Port-level checks of the flash command interface, bound to the top level.
`include "nor_flash_command_interface_unit_assert.svh"

module nfci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_rdata,
    input logic [2:0]  o_mode_now
);

    `NFCI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_rdata) && $stable(o_mode_now))

    `NFCI_ASSERT_SAME(a_mode_range, i_clk, i_rst_n, o_out_valid,
        o_mode_now <= nfci_pkg::MODE_ERASE)

    // outside array mode a result is zero, status or id, all mirrored halves
    `NFCI_ASSERT_SAME(a_mirrored, i_clk, i_rst_n,
        o_out_valid && (o_mode_now != nfci_pkg::MODE_ARRAY),
        o_rdata[31:16] == o_rdata[15:0])

    `NFCI_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind nor_flash_command_interface_unit nfci_checker u_nfci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rdata     (o_rdata),
    .o_mode_now  (o_mode_now)
);
